// File: hw/rtl/bsfp_pkg.sv
// bsfp_pkg: types, constants and codes for the byte stuffed frame packer
// no dependencies; used by bsfp_front, bsfp_queue, bsfp_back and the top
package bsfp_pkg;

  // frame layout
  localparam logic [7:0] MARK_BYTE    = 8'hFF;
  localparam logic [7:0] FILL_BYTE    = 8'h00;
  localparam logic [7:0] OP_BAD_LO    = 8'h00;
  localparam logic [7:0] OP_BAD_HI    = 8'hFF;
  localparam logic [7:0] LEN_MORE     = 8'd13;
  localparam logic [7:0] LEN_LAST     = 8'd12;
  localparam logic [4:0] POS_FIRST    = 5'd3;
  localparam logic [4:0] POS_LAST_PL  = 5'd14;
  localparam logic [4:0] POS_LEN      = 5'd15;
  localparam logic [3:0] PAD_LAST_POS = 4'd14;

  // command queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    END_NONE,
    END_FULL,
    END_PAD
  } end_kind_t;

  typedef enum logic [3:0] {
    PH_FIRST,
    PH_STAT,
    PH_HDR0,
    PH_HDR1,
    PH_HDR2,
    PH_DATA,
    PH_STUFF,
    PH_PAD,
    PH_LEN
  } phase_t;

  // one classified input beat
  typedef struct packed {
    logic       rej;
    logic       hdr;
    logic [7:0] opc;
    logic [7:0] data;
    logic       stuff;
    end_kind_t  end_kind;
    logic [3:0] pad_pos;
    logic [7:0] len_byte;
  } cmd_t;

  // queue handshake between queue and back
  typedef struct packed {
    logic valid;
    logic ready;
  } qhs_t;

endpackage

// File: hw/rtl/bsfp_in_if.sv
// bsfp_in_if: input channel of the frame packer (message bytes)
// no dependencies
interface bsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] opcode;
  logic       message_last;

  modport source (output valid, data_byte, opcode, message_last, input ready);
  modport sink   (input valid, data_byte, opcode, message_last, output ready);
endinterface

// File: hw/rtl/bsfp_out_if.sv
// bsfp_out_if: result channel of the frame packer (frame stream bytes)
// no dependencies
interface bsfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  logic       run_last;
  logic       status;

  modport source (output valid, frame_byte, frame_end, run_last, status, input ready);
  modport sink   (input valid, frame_byte, frame_end, run_last, status, output ready);
endinterface

// File: hw/rtl/bsfp_front.sv
// bsfp_front: accepts message bytes, tracks message and frame state, classifies
// each beat into a command; depends on bsfp_pkg and bsfp_in_if
module bsfp_front (
  input  logic          clk,
  input  logic          rst_n,
  bsfp_in_if.sink       in_ch,
  output bsfp_pkg::cmd_t cmd,
  output logic          push,
  input  logic          q_full
);

  logic       in_msg_r, in_msg_nxt;
  logic       rej_r, rej_nxt;
  logic [7:0] held_r, held_nxt;
  logic [3:0] pos_r, pos_nxt;

  logic [7:0] cur_op;
  logic       cur_rej;
  logic [4:0] cur_pos;
  logic       hdr;
  logic [4:0] p_start;
  logic       stuff;
  logic [4:0] p_after;
  logic       full;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // classify the beat against the current message and frame state
  always_comb begin
    cur_op  = in_msg_r ? held_r : in_ch.opcode;
    cur_rej = in_msg_r ? rej_r
                       : (in_ch.opcode == bsfp_pkg::OP_BAD_LO ||
                          in_ch.opcode == bsfp_pkg::OP_BAD_HI);
    cur_pos = in_msg_r ? {1'b0, pos_r} : 5'd0;
    hdr     = (cur_pos < bsfp_pkg::POS_FIRST) || (cur_pos > bsfp_pkg::POS_LAST_PL);
    p_start = hdr ? bsfp_pkg::POS_FIRST : cur_pos;
    stuff   = (in_ch.data_byte == bsfp_pkg::MARK_BYTE) && (p_start != bsfp_pkg::POS_LAST_PL);
    p_after = p_start + (stuff ? 5'd2 : 5'd1);
    full    = p_after >= bsfp_pkg::POS_LEN;

    cmd.rej     = cur_rej;
    cmd.hdr     = hdr;
    cmd.opc     = cur_op;
    cmd.data    = in_ch.data_byte;
    cmd.stuff   = stuff;
    cmd.pad_pos = p_after[3:0];
    if (full) begin
      cmd.end_kind = bsfp_pkg::END_FULL;
      cmd.len_byte = in_ch.message_last ? bsfp_pkg::LEN_LAST : bsfp_pkg::LEN_MORE;
    end else if (in_ch.message_last) begin
      cmd.end_kind = bsfp_pkg::END_PAD;
      cmd.len_byte = {3'd0, p_after - bsfp_pkg::POS_FIRST};
    end else begin
      cmd.end_kind = bsfp_pkg::END_NONE;
      cmd.len_byte = {3'd0, p_after - bsfp_pkg::POS_FIRST};
    end
  end

  // next message state
  always_comb begin
    if (in_ch.message_last) begin
      in_msg_nxt = 1'b0;
      rej_nxt    = 1'b0;
      held_nxt   = cur_op;
      pos_nxt    = 4'd0;
    end else begin
      in_msg_nxt = 1'b1;
      rej_nxt    = cur_rej;
      held_nxt   = cur_op;
      if (cur_rej) begin
        pos_nxt = cur_pos[3:0];
      end else if (full) begin
        pos_nxt = 4'd0;
      end else begin
        pos_nxt = p_after[3:0];
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      rej_r    <= 1'b0;
      held_r   <= 8'd0;
      pos_r    <= 4'd0;
    end else if (push) begin
      in_msg_r <= in_msg_nxt;
      rej_r    <= rej_nxt;
      held_r   <= held_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

// File: hw/rtl/bsfp_queue.sv
// bsfp_queue: short command queue between front and back
// depends on bsfp_pkg
module bsfp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  bsfp_pkg::cmd_t wr_cmd,
  input  logic           push,
  output logic           full,
  output bsfp_pkg::cmd_t rd_cmd,
  output bsfp_pkg::qhs_t hs_out,
  input  logic           pop
);

  bsfp_pkg::cmd_t mem_r [bsfp_pkg::QDEPTH];
  logic [bsfp_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [bsfp_pkg::QPTR_W:0]   cnt_r, cnt_nxt;
  logic do_pop;

  assign full         = cnt_r == (bsfp_pkg::QPTR_W+1)'(bsfp_pkg::QDEPTH);
  assign hs_out.valid = cnt_r != '0;
  assign hs_out.ready = pop;
  assign do_pop       = pop && hs_out.valid;
  assign rd_cmd       = mem_r[rp_r];

  // fill count
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (!push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_cmd;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/bsfp_back.sv
// bsfp_back: expands queued commands into frame bytes, one beat per cycle
// unless stalled; depends on bsfp_pkg and bsfp_out_if
module bsfp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  bsfp_pkg::cmd_t cmd,
  input  bsfp_pkg::qhs_t q_hs,
  output logic           pop,
  bsfp_out_if.source     out_ch
);

  bsfp_pkg::phase_t phase_r, phase_nxt, cur;
  logic [3:0] pad_r, pad_nxt;
  logic       advance;

  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       end_r, last_r, stat_r;

  logic [7:0] o_byte;
  logic       o_end, o_done, o_stat;

  assign advance = q_hs.valid && (!out_valid_r || out_ch.ready);
  assign pop     = advance && o_done;

  // effective phase of the head command
  always_comb begin
    case (phase_r)
      bsfp_pkg::PH_FIRST: begin
        if (cmd.rej) cur = bsfp_pkg::PH_STAT;
        else if (cmd.hdr) cur = bsfp_pkg::PH_HDR0;
        else cur = bsfp_pkg::PH_DATA;
      end
      default: cur = phase_r;
    endcase
  end

  // next phase and pad counter
  always_comb begin
    phase_nxt = bsfp_pkg::PH_FIRST;
    pad_nxt   = pad_r;
    case (cur)
      bsfp_pkg::PH_HDR0: phase_nxt = bsfp_pkg::PH_HDR1;
      bsfp_pkg::PH_HDR1: phase_nxt = bsfp_pkg::PH_HDR2;
      bsfp_pkg::PH_HDR2: phase_nxt = bsfp_pkg::PH_DATA;
      bsfp_pkg::PH_DATA, bsfp_pkg::PH_STUFF: begin
        pad_nxt = cmd.pad_pos;
        if (cur == bsfp_pkg::PH_DATA && cmd.stuff) phase_nxt = bsfp_pkg::PH_STUFF;
        else if (cmd.end_kind == bsfp_pkg::END_FULL) phase_nxt = bsfp_pkg::PH_LEN;
        else if (cmd.end_kind == bsfp_pkg::END_PAD) phase_nxt = bsfp_pkg::PH_PAD;
        else phase_nxt = bsfp_pkg::PH_FIRST;
      end
      bsfp_pkg::PH_PAD: begin
        pad_nxt = pad_r + 1'b1;
        phase_nxt = (pad_r == bsfp_pkg::PAD_LAST_POS) ? bsfp_pkg::PH_LEN : bsfp_pkg::PH_PAD;
      end
      default: phase_nxt = bsfp_pkg::PH_FIRST;
    endcase
  end

  // beat contents for the current phase
  always_comb begin
    o_byte = bsfp_pkg::FILL_BYTE;
    o_end  = 1'b0;
    o_done = 1'b0;
    o_stat = 1'b0;
    case (cur)
      bsfp_pkg::PH_STAT: begin
        o_stat = 1'b1;
        o_done = 1'b1;
      end
      bsfp_pkg::PH_HDR0, bsfp_pkg::PH_HDR1: o_byte = bsfp_pkg::MARK_BYTE;
      bsfp_pkg::PH_HDR2: o_byte = cmd.opc;
      bsfp_pkg::PH_DATA: begin
        o_byte = cmd.data;
        o_done = !cmd.stuff && (cmd.end_kind == bsfp_pkg::END_NONE);
      end
      bsfp_pkg::PH_STUFF: o_done = cmd.end_kind == bsfp_pkg::END_NONE;
      bsfp_pkg::PH_PAD: o_byte = bsfp_pkg::FILL_BYTE;
      bsfp_pkg::PH_LEN: begin
        o_byte = cmd.len_byte;
        o_end  = 1'b1;
        o_done = 1'b1;
      end
      default: o_byte = bsfp_pkg::FILL_BYTE;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bsfp_pkg::PH_FIRST;
      pad_r   <= 4'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pad_r   <= pad_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r <= o_byte;
      end_r  <= o_end;
      last_r <= o_done;
      stat_r <= o_stat;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = byte_r;
  assign out_ch.frame_end  = end_r;
  assign out_ch.run_last   = last_r;
  assign out_ch.status     = stat_r;

endmodule

// File: hw/rtl/byte_stuffed_frame_packer_top.sv
// byte_stuffed_frame_packer_top: packs message bytes into stuffed 16-byte frames
// accepted beats are queued, then registered in the back output register
// throughput: one input beat a cycle into a 4-deep command queue while it is not
// full; the back sequencer sends one result beat a cycle unless the output stalls
// reset: synchronous active-low rst_n clears message state, queue and output
// depends on bsfp_pkg, bsfp_in_if, bsfp_out_if, bsfp_front, bsfp_queue, bsfp_back
module byte_stuffed_frame_packer_top (
  input  logic        clk,
  input  logic        rst_n,
  bsfp_in_if.sink     in_ch,
  bsfp_out_if.source  out_ch
);

  bsfp_pkg::cmd_t wr_cmd, rd_cmd;
  bsfp_pkg::qhs_t q_hs;
  logic push, q_full, pop;

  // front: accept and classify
  bsfp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cmd    (wr_cmd),
    .push   (push),
    .q_full (q_full)
  );

  // command queue
  bsfp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_cmd (wr_cmd),
    .push   (push),
    .full   (q_full),
    .rd_cmd (rd_cmd),
    .hs_out (q_hs),
    .pop    (pop)
  );

  // back: frame byte sequencer
  bsfp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (rd_cmd),
    .q_hs   (q_hs),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
